// ----- src/l4fk_pkg.sv -----
package l4fk_pkg;

    // Saturating byte counter
    localparam int          COUNT_W   = 17;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // Result status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_VER  = 3'd2;
    localparam logic [2:0] ST_FRAG = 3'd3;
    localparam logic [2:0] ST_EXT  = 3'd4;

    localparam logic [3:0] IPV4_VER = 4'd4;
    localparam logic [3:0] IPV6_VER = 4'd6;

    // Protocol / next-header numbers
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
    localparam logic [7:0] PROTO_ROUTING = 8'd43;
    localparam logic [7:0] PROTO_FRAG    = 8'd44;
    localparam logic [7:0] PROTO_AH      = 8'd51;
    localparam logic [7:0] PROTO_DSTOPT  = 8'd60;

    // Header sizes in bytes
    localparam logic [6:0] IPV4_MIN_HDR = 7'd20;
    localparam logic [6:0] IPV6_HDR     = 7'd40;
    localparam logic [6:0] TCP_MIN_HDR  = 7'd20;
    localparam logic [6:0] UDP_HDR      = 7'd8;

    localparam int RES_W = 358;
    localparam int OUT_W = 360;

    // Per-packet capture state
    typedef struct packed {
        logic [16:0] count;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] ip_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [15:0] tlen;
        logic [3:0]  tflags;
    } flow_state_t;

    // Result, last member in the lowest bits
    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [31:0] sequence_number;
        logic [6:0]  flag_bits;
        logic [15:0] port_b;
        logic [15:0] port_a;
        logic [63:0] addr_b_low;
        logic [63:0] addr_b_high;
        logic [63:0] addr_a_low;
        logic [63:0] addr_a_high;
        logic [7:0]  protocol;
        logic [3:0]  ip_version;
        logic [2:0]  status;
    } result_t;

endpackage

// ----- src/ip_l4_flow_key_parser.sv -----
// IPv4/IPv6 TCP/UDP flow key parser. Packet bytes arrive on the slave stream one
// request per byte, starting at the IP header, with tlast on the final byte. The
// block takes one byte every cycle with no gaps between packets, except that a final
// byte waits for a free snapshot slot; each byte only updates a positional capture
// and the byte count. On the final byte the captured header state is moved to a
// snapshot register and the working state is cleared, so the next packet may start
// in the very next cycle. From the snapshot the length checks, rejection rules and
// canonical endpoint ordering are evaluated and loaded into the output register once
// it is free. The output register and the snapshot register decouple the two sides,
// so a stalled result only holds input once the snapshot is full and a further final
// byte arrives. Non-final bytes never produce a result. On rejection only status,
// ip_version and fragment flag bits are nonzero.
module ip_l4_flow_key_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] packet_byte
    input  logic                      s_axis_tlast,   // last_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [2:0] status, [6:3] ip_version, [14:7] protocol, [78:15] addr_a_high,
    // [142:79] addr_a_low, [206:143] addr_b_high, [270:207] addr_b_low,
    // [286:271] port_a, [302:287] port_b, [309:303] flag_bits,
    // [341:310] sequence_number, [357:342] payload_bytes, [359:358] zero
    output logic [l4fk_pkg::OUT_W-1:0] m_axis_tdata
);
    import l4fk_pkg::*;

    // Input register
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Working capture state and end-of-packet snapshot
    flow_state_t st_reg, st_next, cap;
    logic        snap_v_reg, snap_v_next;
    flow_state_t snap_reg;

    // Output register
    logic    out_v_reg, out_v_next;
    result_t out_reg, res;

    logic out_ready, snap_ready, snap_go, cap_go;

    assign out_ready     = !out_v_reg || m_axis_tready;
    assign snap_ready    = !snap_v_reg || out_ready;
    assign snap_go       = snap_v_reg && out_ready;
    // A final byte needs a free snapshot slot; other bytes always move on
    assign cap_go        = in_v_reg && (!in_last_reg || snap_ready);
    assign s_axis_tready = !in_v_reg || cap_go;

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, out_reg};

    //------------------------------------------------------------------------
    // Positional capture of the registered byte
    //------------------------------------------------------------------------
    logic [16:0] pos;
    logic [16:0] off;
    logic [16:0] rel;
    logic        is4, is6;

    always_comb
    begin
        pos = st_reg.count;
        cap = st_reg;
        off = 17'd0;
        rel = 17'd0;

        // Version and header length take effect for this same byte
        if (pos == 17'd0)
        begin
            cap.ver = in_byte_reg[7:4];
            cap.ihl = in_byte_reg[3:0];
        end
        is4 = (cap.ver == IPV4_VER);
        is6 = (cap.ver == IPV6_VER);

        if (is4)
        begin
            off = {11'd0, cap.ihl, 2'b00};
            if (pos == 17'd2 || pos == 17'd3)
                cap.ip_len = {cap.ip_len[7:0], in_byte_reg};
            if (pos == 17'd6 || pos == 17'd7)
                cap.frag = {cap.frag[7:0], in_byte_reg};
            if (pos == 17'd9)
                cap.proto = in_byte_reg;
            if (pos >= 17'd12 && pos <= 17'd15)
                cap.src_lo = {cap.src_lo[55:0], in_byte_reg};
            if (pos >= 17'd16 && pos <= 17'd19)
                cap.dst_lo = {cap.dst_lo[55:0], in_byte_reg};
        end
        else if (is6)
        begin
            off = {10'd0, IPV6_HDR};
            if (pos == 17'd4 || pos == 17'd5)
                cap.ip_len = {cap.ip_len[7:0], in_byte_reg};
            if (pos == 17'd6)
                cap.proto = in_byte_reg;
            if (pos >= 17'd8 && pos <= 17'd15)
                cap.src_hi = {cap.src_hi[55:0], in_byte_reg};
            if (pos >= 17'd16 && pos <= 17'd23)
                cap.src_lo = {cap.src_lo[55:0], in_byte_reg};
            if (pos >= 17'd24 && pos <= 17'd31)
                cap.dst_hi = {cap.dst_hi[55:0], in_byte_reg};
            if (pos >= 17'd32 && pos <= 17'd39)
                cap.dst_lo = {cap.dst_lo[55:0], in_byte_reg};
        end

        // Transport header; protocol byte also counts for this same byte
        if ((is4 || is6) && pos >= off)
        begin
            rel = pos - off;
            if (rel == 17'd0 || rel == 17'd1)
                cap.sport = {cap.sport[7:0], in_byte_reg};
            if (rel == 17'd2 || rel == 17'd3)
                cap.dport = {cap.dport[7:0], in_byte_reg};
            if (cap.proto == PROTO_TCP)
            begin
                if (rel >= 17'd4 && rel <= 17'd7)
                    cap.seq = {cap.seq[23:0], in_byte_reg};
                if (rel == 17'd12)
                    cap.tlen = {10'd0, in_byte_reg[7:4], 2'b00};
                if (rel == 17'd13)
                    cap.tflags = {in_byte_reg[2], in_byte_reg[0],
                                  in_byte_reg[4], in_byte_reg[1]};
            end
            else if (cap.proto == PROTO_UDP)
            begin
                if (rel == 17'd4 || rel == 17'd5)
                    cap.tlen = {cap.tlen[7:0], in_byte_reg};
            end
        end

        if (pos != COUNT_MAX)
            cap.count = pos + 17'd1;
    end

    always_comb
    begin
        st_next = st_reg;
        if (cap_go)
            st_next = in_last_reg ? '0 : cap;
    end

    assign snap_v_next = (cap_go && in_last_reg) ? 1'b1 : (snap_go ? 1'b0 : snap_v_reg);
    assign out_v_next  = snap_go ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_reg);

    //------------------------------------------------------------------------
    // End-of-packet checks and canonical ordering, from the snapshot
    //------------------------------------------------------------------------
    logic [2:0]  status;
    logic [1:0]  frag_bits;
    logic [16:0] len;
    logic [16:0] eff_len;
    logic [16:0] tot;
    logic [6:0]  hoff;
    logic [17:0] len18;
    logic [17:0] off18;
    logic [15:0] sp, dp, pay;
    logic [3:0]  tfl;
    logic [31:0] sq;
    logic [17:0] pay18;
    logic        src_a;

    always_comb
    begin
        status    = ST_OK;
        frag_bits = 2'b00;
        len       = snap_reg.count;
        eff_len   = len;
        tot       = 17'd0;
        hoff      = 7'd0;
        sp        = 16'd0;
        dp        = 16'd0;
        pay       = 16'd0;
        tfl       = 4'd0;
        sq        = 32'd0;
        pay18     = 18'd0;

        if (snap_reg.ver == IPV4_VER)
        begin
            hoff = {1'b0, snap_reg.ihl, 2'b00};
            tot  = {1'b0, snap_reg.ip_len};
            if (len < {10'd0, IPV4_MIN_HDR} || hoff < IPV4_MIN_HDR ||
                {10'd0, hoff} > len || tot < {10'd0, hoff} || tot > len)
                status = ST_LEN;
            else
            begin
                frag_bits = {snap_reg.frag[12:0] != 13'd0, snap_reg.frag[13]};
                if (frag_bits != 2'b00)
                    status = ST_FRAG;
            end
            eff_len = tot;
        end
        else if (snap_reg.ver == IPV6_VER)
        begin
            hoff = IPV6_HDR;
            tot  = {10'd0, IPV6_HDR} + {1'b0, snap_reg.ip_len};
            if (len < {10'd0, IPV6_HDR} || tot > len)
                status = ST_LEN;
            else if (snap_reg.proto == PROTO_FRAG)
            begin
                status    = ST_FRAG;
                frag_bits = 2'b10;
            end
            else if (snap_reg.proto == PROTO_HOPOPT || snap_reg.proto == PROTO_ROUTING ||
                     snap_reg.proto == PROTO_DSTOPT || snap_reg.proto == PROTO_AH)
                status = ST_EXT;
            eff_len = tot;
        end
        else
            status = ST_VER;

        len18 = {1'b0, eff_len};
        off18 = {11'd0, hoff};

        if (status == ST_OK)
        begin
            if (snap_reg.proto == PROTO_TCP)
            begin
                if (off18 + {11'd0, TCP_MIN_HDR} > len18 ||
                    snap_reg.tlen < {9'd0, TCP_MIN_HDR} ||
                    off18 + {2'b00, snap_reg.tlen} > len18)
                    status = ST_LEN;
                else
                begin
                    sp    = snap_reg.sport;
                    dp    = snap_reg.dport;
                    tfl   = snap_reg.tflags;
                    sq    = snap_reg.seq;
                    pay18 = len18 - off18 - {2'b00, snap_reg.tlen};
                    pay   = pay18[15:0];
                end
            end
            else if (snap_reg.proto == PROTO_UDP)
            begin
                if (off18 + {11'd0, UDP_HDR} > len18 ||
                    snap_reg.tlen < {9'd0, UDP_HDR} ||
                    off18 + {2'b00, snap_reg.tlen} > len18)
                    status = ST_LEN;
                else
                begin
                    sp  = snap_reg.sport;
                    dp  = snap_reg.dport;
                    pay = snap_reg.tlen - {9'd0, UDP_HDR};
                end
            end
        end

        // Equal keys keep the source as endpoint a
        src_a = {snap_reg.src_hi, snap_reg.src_lo, sp} <=
                {snap_reg.dst_hi, snap_reg.dst_lo, dp};

        res            = '0;
        res.status     = status;
        res.ip_version = snap_reg.ver;
        if (status == ST_OK)
        begin
            res.protocol        = snap_reg.proto;
            res.addr_a_high     = src_a ? snap_reg.src_hi : snap_reg.dst_hi;
            res.addr_a_low      = src_a ? snap_reg.src_lo : snap_reg.dst_lo;
            res.addr_b_high     = src_a ? snap_reg.dst_hi : snap_reg.src_hi;
            res.addr_b_low      = src_a ? snap_reg.dst_lo : snap_reg.src_lo;
            res.port_a          = src_a ? sp : dp;
            res.port_b          = src_a ? dp : sp;
            res.flag_bits       = {src_a, 2'b00, tfl};
            res.sequence_number = sq;
            res.payload_bytes   = pay;
        end
        else
            res.flag_bits = {1'b0, frag_bits, 4'd0};
    end

    //------------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            st_reg     <= '0;
            snap_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_v_reg <= s_axis_tvalid;
            st_reg     <= st_next;
            snap_v_reg <= snap_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (cap_go && in_last_reg)
            snap_reg <= cap;
        if (snap_go)
            out_reg <= res;
    end

    //------------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------------
    a_ok_version: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg.status == ST_OK |->
            out_reg.ip_version == IPV4_VER || out_reg.ip_version == IPV6_VER)
        else $error("accepted result with bad IP version");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg.status != ST_OK |->
            out_reg.protocol == 8'd0 && out_reg.port_a == 16'd0 &&
            out_reg.port_b == 16'd0 && out_reg.addr_a_low == 64'd0 &&
            out_reg.addr_b_low == 64'd0 && out_reg.payload_bytes == 16'd0)
        else $error("rejected result carries key fields");

    a_snap_load: assert property (@(posedge clk) disable iff (!rst_n)
        cap_go && in_last_reg |=> snap_v_reg)
        else $error("final byte did not reach snapshot");

    a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cap_go && in_last_reg |=> st_reg.count == 17'd0 && st_reg.ver == 4'd0)
        else $error("capture state not cleared after final byte");

endmodule

// ----- tb/tb.sv -----
module tb;

    import l4fk_pkg::*;

    // Protocol numbers used by stimulus only
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    // IPv4 flags/fragment-offset word
    localparam logic [15:0] FRAG_DF    = 16'h4000;
    localparam logic [15:0] FRAG_MF    = 16'h2000;

    // No request on either side for this many cycles ends the run
    localparam int WATCHDOG_LIMIT = 500;
    // Slack after the last pending key has been checked
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_BYTES   = 800;
    localparam int RANDOM_PACKETS = 48;
    // Longer than the byte counter can count, to hit saturation
    localparam int LONG_PACKET    = 131075;

    typedef logic [7:0] byte_q_t[$];

    // Recipe for one packet; the stream is built from it
    typedef struct {
        logic [3:0]  ver_nib;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] frag;
        logic [63:0] s_hi;
        logic [63:0] s_lo;
        logic [63:0] d_hi;
        logic [63:0] d_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  doff;
        logic [7:0]  tcp_flags;
        logic [31:0] seq;
        int          payload_len;
        int          udp_adj;    // error added to UDP length field
        int          decl_adj;   // error added to IP length field
        int          pad;        // bytes past the IP-declared length
        int          cut;        // truncate stream to this many bytes (0: none)
    } pkt_spec_t;

    // Flow key predictor plus the queue of keys still owed by the block
    class flow_key_checker;
        logic [16:0] cnt;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] ip_len;
        logic [15:0] frag_w;
        logic [7:0]  proto;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [15:0] tlen;
        logic [3:0]  tflg;

        result_t pending_keys[$];
        int errors;
        int reported;
        int checked;
        int keys;
        int bytes;
        int status_hits[5];

        function new();
            clear();
        endfunction

        function void clear();
            cnt = '0; ver = '0; ihl = '0; ip_len = '0; frag_w = '0; proto = '0;
            src_hi = '0; src_lo = '0; dst_hi = '0; dst_lo = '0;
            sport = '0; dport = '0; seq = '0; tlen = '0; tflg = '0;
        endfunction

        // Positional capture of byte b at offset p
        function void capture(int unsigned p, logic [7:0] b);
            int unsigned off;
            int unsigned r;
            if (p == 0) begin
                ver = b[7:4];
                ihl = b[3:0];
            end
            if (ver == IPV4_VER) begin
                off = 4 * ihl;
                if (p == 2 || p == 3) ip_len = {ip_len[7:0], b};
                if (p == 6 || p == 7) frag_w = {frag_w[7:0], b};
                if (p == 9) proto = b;
                if (p >= 12 && p <= 15) src_lo = {src_lo[55:0], b};
                if (p >= 16 && p <= 19) dst_lo = {dst_lo[55:0], b};
            end else if (ver == IPV6_VER) begin
                off = IPV6_HDR;
                if (p == 4 || p == 5) ip_len = {ip_len[7:0], b};
                if (p == 6) proto = b;
                if (p >= 8 && p <= 15) src_hi = {src_hi[55:0], b};
                if (p >= 16 && p <= 23) src_lo = {src_lo[55:0], b};
                if (p >= 24 && p <= 31) dst_hi = {dst_hi[55:0], b};
                if (p >= 32 && p <= 39) dst_lo = {dst_lo[55:0], b};
            end else begin
                return;
            end
            if (p >= off) begin
                r = p - off;
                if (r == 0 || r == 1) sport = {sport[7:0], b};
                if (r == 2 || r == 3) dport = {dport[7:0], b};
                if (proto == PROTO_TCP) begin
                    if (r >= 4 && r <= 7) seq = {seq[23:0], b};
                    if (r == 12) tlen = {10'd0, b[7:4], 2'b00};
                    // syn, ack, fin, rst from the low bit up
                    if (r == 13) tflg = {b[2], b[0], b[4], b[1]};
                end else if (proto == PROTO_UDP) begin
                    if (r == 4 || r == 5) tlen = {tlen[7:0], b};
                end
            end
        endfunction

        // Length rules, rejection and endpoint ordering at the last byte
        function result_t conclude();
            result_t     k;
            int unsigned len;
            int unsigned off;
            int unsigned tot;
            int unsigned tl;
            logic [15:0] sp;
            logic [15:0] dp;
            logic [15:0] pay;
            logic [31:0] sq;
            logic [3:0]  tf;
            logic [6:0]  fl;
            bit          src_a;
            k = '0;
            k.ip_version = ver;
            len = cnt;
            if (ver == IPV4_VER) begin
                off = 4 * ihl;
                tot = ip_len;
                if (len < IPV4_MIN_HDR || off < IPV4_MIN_HDR || off > len ||
                    tot < off || tot > len) begin
                    k.status = ST_LEN;
                    return k;
                end
                len = tot;
                fl = '0;
                fl[4] = frag_w[13];
                fl[5] = (frag_w[12:0] != 0);
                if (fl != 0) begin
                    k.flag_bits = fl;
                    k.status = ST_FRAG;
                    return k;
                end
            end else if (ver == IPV6_VER) begin
                off = IPV6_HDR;
                tot = IPV6_HDR + ip_len;
                if (len < IPV6_HDR || tot > len) begin
                    k.status = ST_LEN;
                    return k;
                end
                len = tot;
                if (proto == PROTO_FRAG) begin
                    k.flag_bits = 7'h20;
                    k.status = ST_FRAG;
                    return k;
                end
                if (proto == PROTO_HOPOPT || proto == PROTO_ROUTING ||
                    proto == PROTO_DSTOPT || proto == PROTO_AH) begin
                    k.status = ST_EXT;
                    return k;
                end
            end else begin
                k.status = ST_VER;
                return k;
            end
            sp = '0; dp = '0; pay = '0; sq = '0; tf = '0;
            tl = tlen;
            if (proto == PROTO_TCP) begin
                if (off + TCP_MIN_HDR > len || tl < TCP_MIN_HDR || off + tl > len) begin
                    k.status = ST_LEN;
                    return k;
                end
                sp = sport; dp = dport; tf = tflg; sq = seq;
                pay = 16'(len - off - tl);
            end else if (proto == PROTO_UDP) begin
                if (off + UDP_HDR > len || tl < UDP_HDR || off + tl > len) begin
                    k.status = ST_LEN;
                    return k;
                end
                sp = sport; dp = dport;
                pay = 16'(tl - UDP_HDR);
            end
            // Lower address first, then lower port; a tie keeps the source as a
            if (src_hi != dst_hi)      src_a = (src_hi < dst_hi);
            else if (src_lo != dst_lo) src_a = (src_lo < dst_lo);
            else                       src_a = (sp <= dp);
            k.status          = ST_OK;
            k.protocol        = proto;
            k.addr_a_high     = src_a ? src_hi : dst_hi;
            k.addr_a_low      = src_a ? src_lo : dst_lo;
            k.addr_b_high     = src_a ? dst_hi : src_hi;
            k.addr_b_low      = src_a ? dst_lo : src_lo;
            k.port_a          = src_a ? sp : dp;
            k.port_b          = src_a ? dp : sp;
            k.flag_bits       = {src_a, 2'b00, tf};
            k.sequence_number = sq;
            k.payload_bytes   = pay;
            return k;
        endfunction

        // Called for every byte request taken by the block
        function void take_byte(logic [7:0] b, bit last);
            result_t k;
            capture(cnt, b);
            if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
            bytes++;
            if (last) begin
                k = conclude();
                pending_keys.push_back(k);
                status_hits[k.status]++;
                keys++;
                clear();
            end
        endfunction

        function void flag_error(string msg);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("ERROR: %s", msg);
            end
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
                flag_error($sformatf("key %0d %s: expected %0h, got %0h",
                                     checked, name, want, got));
        endfunction

        // Called for every result request taken from the block
        function void check_key(logic [OUT_W-1:0] d);
            result_t got;
            result_t want;
            got = d[RES_W-1:0];
            checked++;
            if (pending_keys.size() == 0) begin
                flag_error($sformatf("key %0d arrived with none pending", checked));
                return;
            end
            want = pending_keys.pop_front();
            cmp("status",          want.status,          got.status);
            cmp("ip_version",      want.ip_version,      got.ip_version);
            cmp("protocol",        want.protocol,        got.protocol);
            cmp("addr_a_high",     want.addr_a_high,     got.addr_a_high);
            cmp("addr_a_low",      want.addr_a_low,      got.addr_a_low);
            cmp("addr_b_high",     want.addr_b_high,     got.addr_b_high);
            cmp("addr_b_low",      want.addr_b_low,      got.addr_b_low);
            cmp("port_a",          want.port_a,          got.port_a);
            cmp("port_b",          want.port_b,          got.port_b);
            cmp("flag_bits",       want.flag_bits,       got.flag_bits);
            cmp("sequence_number", want.sequence_number, got.sequence_number);
            cmp("payload_bytes",   want.payload_bytes,   got.payload_bytes);
            cmp("padding",         '0,                   d[OUT_W-1:RES_W]);
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;   // [7:0] packet_byte
    logic               s_axis_tlast  = 1'b0; // last_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [2:0] status, [6:3] ip_version, [14:7] protocol, [78:15] addr_a_high,
    // [142:79] addr_a_low, [206:143] addr_b_high, [270:207] addr_b_low,
    // [286:271] port_a, [302:287] port_b, [309:303] flag_bits,
    // [341:310] sequence_number, [357:342] payload_bytes, [359:358] zero
    logic [OUT_W-1:0]   m_axis_tdata;

    flow_key_checker board = new();
    bit quiet = 1'b0;       // both sides stop idling while set
    int idle_cycles = 0;
    int random_pkts = 0;

    ip_l4_flow_key_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Big-endian append of the low n bytes of v
    function automatic void put(ref byte_q_t q, input logic [63:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
    endfunction

    // Lays out IP header, TCP/UDP header, payload and padding from a recipe.
    // Any version other than 6 uses the IPv4 layout.
    function automatic byte_q_t build_packet(pkt_spec_t s);
        byte_q_t q;
        byte_q_t l4;
        int      hphys;
        int      tphys;
        int      i;
        if (s.proto == PROTO_TCP) begin
            tphys = 4 * s.doff;
            if (tphys < TCP_MIN_HDR) tphys = TCP_MIN_HDR;
            put(l4, s.sport, 2);
            put(l4, s.dport, 2);
            put(l4, s.seq, 4);
            put(l4, $urandom, 4);
            l4.push_back({s.doff, 4'($urandom)});
            l4.push_back(s.tcp_flags);
            put(l4, {$urandom, $urandom}, 6);
            while (l4.size() < tphys) l4.push_back(8'($urandom));
        end else if (s.proto == PROTO_UDP) begin
            put(l4, s.sport, 2);
            put(l4, s.dport, 2);
            put(l4, UDP_HDR + s.payload_len + s.udp_adj, 2);
            put(l4, $urandom, 2);
        end
        for (i = 0; i < s.payload_len; i++) l4.push_back(8'($urandom));

        if (s.ver_nib == IPV6_VER) begin
            q.push_back({IPV6_VER, 4'($urandom)});
            put(q, $urandom, 3);
            put(q, l4.size() + s.decl_adj, 2);
            q.push_back(s.proto);
            q.push_back(8'($urandom));
            put(q, s.s_hi, 8);
            put(q, s.s_lo, 8);
            put(q, s.d_hi, 8);
            put(q, s.d_lo, 8);
        end else begin
            hphys = 4 * s.ihl;
            if (hphys < IPV4_MIN_HDR) hphys = IPV4_MIN_HDR;
            q.push_back({s.ver_nib, s.ihl});
            q.push_back(8'($urandom));
            put(q, hphys + l4.size() + s.decl_adj, 2);
            put(q, $urandom, 2);
            put(q, s.frag, 2);
            q.push_back(8'($urandom));
            q.push_back(s.proto);
            put(q, $urandom, 2);
            put(q, s.s_lo, 4);
            put(q, s.d_lo, 4);
            while (q.size() < hphys) q.push_back(8'($urandom));
        end
        q = {q, l4};
        for (i = 0; i < s.pad; i++) q.push_back(8'($urandom));
        if (s.cut > 0 && s.cut < q.size()) q = q[0:s.cut-1];
        return q;
    endfunction

    // Clean, well-formed packet with random addresses and ports
    function automatic pkt_spec_t base_spec(logic [3:0] ver, logic [7:0] proto);
        pkt_spec_t s;
        s.ver_nib     = ver;
        s.ihl         = 4'd5;
        s.proto       = proto;
        s.frag        = '0;
        s.s_hi        = {$urandom, $urandom};
        s.s_lo        = {$urandom, $urandom};
        s.d_hi        = {$urandom, $urandom};
        s.d_lo        = {$urandom, $urandom};
        s.sport       = 16'($urandom);
        s.dport       = 16'($urandom);
        s.doff        = 4'd5;
        s.tcp_flags   = 8'($urandom);
        s.seq         = $urandom;
        s.payload_len = 0;
        s.udp_adj     = 0;
        s.decl_adj    = 0;
        s.pad         = 0;
        s.cut         = 0;
        return s;
    endfunction

    // Mostly well-formed packets; a fraction carry header and length errors
    function automatic pkt_spec_t random_spec();
        pkt_spec_t s;
        int        pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)      s = base_spec(IPV4_VER, PROTO_TCP);
        else if (pick <= 6) s = base_spec(IPV4_VER, PROTO_UDP);
        else if (pick == 7) s = base_spec(IPV4_VER, 8'($urandom));
        else if (pick == 8) s = base_spec(IPV4_VER, PROTO_ICMP);
        else begin
            case ($urandom_range(0, 4))
                0: s = base_spec(IPV4_VER, PROTO_HOPOPT);
                1: s = base_spec(IPV4_VER, PROTO_ROUTING);
                2: s = base_spec(IPV4_VER, PROTO_FRAG);
                3: s = base_spec(IPV4_VER, PROTO_AH);
                default: s = base_spec(IPV4_VER, PROTO_DSTOPT);
            endcase
        end
        if ($urandom_range(0, 1) == 0) s.ver_nib = IPV6_VER;
        if ($urandom_range(0, 19) == 0) s.ver_nib = 4'($urandom);
        s.ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7));
        s.doff = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
        if ($urandom_range(0, 5) == 0)      s.frag = 16'($urandom);
        else if ($urandom_range(0, 1) == 0) s.frag = FRAG_DF;
        // Equal or half-equal endpoints exercise the tie-breaks
        case ($urandom_range(0, 7))
            0: begin s.d_hi = s.s_hi; s.d_lo = s.s_lo; end
            1: s.d_hi = s.s_hi;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) s.dport = s.sport;
        s.payload_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                    : $urandom_range(0, 24);
        if ($urandom_range(0, 7) == 0) s.udp_adj  = int'($urandom_range(0, 20)) - 10;
        if ($urandom_range(0, 7) == 0) s.decl_adj = int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 4) == 0) s.pad      = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) s.cut      = $urandom_range(1, 60);
        return s;
    endfunction

    // One byte request; tvalid only drops when a gap is drawn
    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        board.take_byte(b, last);
    endtask

    task automatic send_packet(byte_q_t q);
        int i;
        for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic run_directed();
        pkt_spec_t s;
        int        i;
        logic [7:0] ext_hdr[5];
        ext_hdr = '{PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAG, PROTO_AH, PROTO_DSTOPT};

        // Minimal TCP, address and port extremes
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.s_lo = '0; s.d_lo = '1; s.sport = '0; s.dport = '1; s.tcp_flags = '0;
        send_packet(build_packet(s));
        // All TCP flags, max sequence, longest data offset, source ordered second
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.s_lo = '1; s.d_lo = '0; s.tcp_flags = '1; s.seq = '1; s.doff = 4'd15;
        s.payload_len = 10; s.ihl = 4'd15;
        send_packet(build_packet(s));
        // TCP data offset below the minimum
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.doff = 4'd4;
        send_packet(build_packet(s));
        // UDP equal addresses: ports decide, then a full tie
        s = base_spec(IPV4_VER, PROTO_UDP);
        s.d_lo = s.s_lo; s.sport = 16'hFFFF; s.dport = 16'h0001; s.payload_len = 5;
        send_packet(build_packet(s));
        s.dport = s.sport;
        send_packet(build_packet(s));
        // UDP length too short, then past the packet
        s = base_spec(IPV4_VER, PROTO_UDP);
        s.udp_adj = -1;
        send_packet(build_packet(s));
        s.udp_adj = 3;
        send_packet(build_packet(s));
        // Other transport is accepted without ports
        s = base_spec(IPV4_VER, PROTO_ICMP);
        s.payload_len = 12;
        send_packet(build_packet(s));
        // IHL below 20 bytes
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.ihl = 4'd4;
        send_packet(build_packet(s));
        // Trailing bytes trimmed to the total length, then a length too big
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.pad = 6; s.payload_len = 3;
        send_packet(build_packet(s));
        s.pad = 0; s.decl_adj = 1;
        send_packet(build_packet(s));
        // Fragments: more-fragments, offset, both
        s = base_spec(IPV4_VER, PROTO_UDP);
        s.frag = FRAG_MF;
        send_packet(build_packet(s));
        s.frag = 16'h0001;
        send_packet(build_packet(s));
        s.frag = 16'h3FFF;
        send_packet(build_packet(s));
        // Short packets: one byte each, and a header cut by one
        send_packet('{8'h45});
        send_packet('{8'h00});
        s = base_spec(IPV4_VER, PROTO_TCP);
        s.cut = 19;
        send_packet(build_packet(s));
        // Unknown version with a full header
        s = base_spec(4'hF, PROTO_TCP);
        send_packet(build_packet(s));
        // IPv6 TCP with address extremes, UDP with equal upper halves
        s = base_spec(IPV6_VER, PROTO_TCP);
        s.s_hi = '0; s.s_lo = '0; s.d_hi = '1; s.d_lo = '1; s.payload_len = 4;
        send_packet(build_packet(s));
        s = base_spec(IPV6_VER, PROTO_UDP);
        s.d_hi = s.s_hi; s.payload_len = 3; s.pad = 4;
        send_packet(build_packet(s));
        // IPv6 extension headers and fragment header
        for (i = 0; i < 5; i++) begin
            s = base_spec(IPV6_VER, ext_hdr[i]);
            send_packet(build_packet(s));
        end
        // IPv6 cut inside the fixed header, then payload length too big
        s = base_spec(IPV6_VER, PROTO_TCP);
        s.cut = 39;
        send_packet(build_packet(s));
        s.cut = 0; s.decl_adj = 1;
        send_packet(build_packet(s));
        // Max total length and payload; stream runs past count saturation
        s = base_spec(IPV4_VER, PROTO_UDP);
        s.payload_len = 16'hFFFF - IPV4_MIN_HDR - UDP_HDR;
        s.pad = LONG_PACKET - 16'hFFFF;
        quiet = 1'b1;
        send_packet(build_packet(s));
        quiet = 1'b0;
    endtask

    task automatic run_random();
        byte_q_t q;
        int      start_bytes;
        int      n;
        int      i;
        start_bytes = board.bytes;
        while (board.bytes - start_bytes < RANDOM_BYTES || random_pkts < RANDOM_PACKETS) begin
            if ($urandom_range(0, 19) == 0) begin
                // Noise: random bytes of random length
                q.delete();
                n = $urandom_range(1, 50);
                for (i = 0; i < n; i++) q.push_back(8'($urandom));
            end else begin
                q = build_packet(random_spec());
            end
            quiet = ($urandom_range(0, 5) == 0);
            send_packet(q);
            random_pkts++;
        end
        quiet = 1'b0;
    endtask

    // Result side: a drawn stall is held once a result is waiting
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                do @(posedge clk); while (!m_axis_tvalid);
                repeat (gap - 1) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_key(m_axis_tdata);
        end
    end

    // Stall detector: ends the run when neither side moves a request
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (board.pending_keys.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d packets in %0d bytes, %0d flow keys checked, %0d errors",
                 board.keys, board.bytes, board.checked, board.errors);
        $display("Status mix: ok %0d, length %0d, version %0d, fragment %0d, ext hdr %0d",
                 board.status_hits[ST_OK], board.status_hits[ST_LEN],
                 board.status_hits[ST_VER], board.status_hits[ST_FRAG],
                 board.status_hits[ST_EXT]);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/l4fk_pkg.sv
src/ip_l4_flow_key_parser.sv
tb/tb.sv
